/* hw/rtl/tdf_pkg.sv */
// Package for the trial-division factorizer.
// Holds the sequencer state type and the fixed codes; no dependencies.
package tdf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_CHECK,
    ST_DIV,
    ST_FLUSH
  } state_e;

  // Status codes carried on each result word.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BELOW_TWO = 1'b1;

  // First odd trial divisor and the smallest value that has a prime factor.
  localparam int unsigned FIRST_ODD = 3;
  localparam int unsigned MIN_VALUE = 2;

endpackage

/* hw/rtl/trial_division_factorizer.sv */
// Trial-division factorizer: one number in, its prime factors out in ascending order.
// Factors of two are shifted out first, then each odd trial divisor takes one pass
// through the bit-serial divider; a 32-bit prime needs roughly 32768 divisions.
// Throughput: one number at a time; busy stays high until the last word is registered for valid_o.
// Reset (async, active low) returns the sequencer to idle and drops any pending word.
// Result words come one cycle wide on valid_o and cannot be stalled.
module trial_division_factorizer #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] number_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] factor_o,
  output logic             last_o,
  output logic             status_o
);

  localparam int unsigned SqW = WIDTH + 2;

  tdf_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] d_q, d_d;
  logic [SqW-1:0]   sq_q, sq_d;
  logic [WIDTH-1:0] pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;

  logic             valid_q, valid_d;
  logic [WIDTH-1:0] factor_q, factor_d;
  logic             last_q, last_d;
  logic             status_q, status_d;

  logic             accept;
  logic             below_two;
  logic             bound_hit;
  logic             div_start;
  logic             div_done;
  logic [WIDTH-1:0] div_quot;
  logic [WIDTH-1:0] div_rem;

  assign accept    = start && (state_q == tdf_pkg::ST_IDLE);
  assign below_two = number_i < WIDTH'(tdf_pkg::MIN_VALUE);
  assign bound_hit = sq_q > {2'b00, n_q};

  tdf_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tdf_pkg::ST_IDLE: begin
        if (accept && !below_two) begin
          state_d = tdf_pkg::ST_TWOS;
        end
      end
      tdf_pkg::ST_TWOS: begin
        if (n_q[0]) begin
          state_d = tdf_pkg::ST_CHECK;
        end
      end
      tdf_pkg::ST_CHECK: begin
        state_d = bound_hit ? tdf_pkg::ST_FLUSH : tdf_pkg::ST_DIV;
      end
      tdf_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = tdf_pkg::ST_CHECK;
        end
      end
      tdf_pkg::ST_FLUSH: state_d = tdf_pkg::ST_IDLE;
      default:           state_d = tdf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output words. A found factor is held back one step so that
  // the last flag can be set once it is known that no further factor follows.
  always_comb begin
    n_d          = n_q;
    d_d          = d_q;
    sq_d         = sq_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    valid_d      = 1'b0;
    factor_d     = factor_q;
    last_d       = 1'b0;
    status_d     = tdf_pkg::STATUS_OK;
    div_start    = 1'b0;
    case (state_q)
      tdf_pkg::ST_IDLE: begin
        if (accept) begin
          n_d          = number_i;
          pend_valid_d = 1'b0;
          if (below_two) begin
            valid_d  = 1'b1;
            factor_d = '0;
            last_d   = 1'b1;
            status_d = tdf_pkg::STATUS_BELOW_TWO;
          end
        end
      end
      tdf_pkg::ST_TWOS: begin
        if (n_q[0]) begin
          d_d  = WIDTH'(tdf_pkg::FIRST_ODD);
          sq_d = SqW'(tdf_pkg::FIRST_ODD * tdf_pkg::FIRST_ODD);
        end else begin
          n_d          = {1'b0, n_q[WIDTH-1:1]};
          valid_d      = pend_valid_q;
          factor_d     = pend_q;
          pend_d       = WIDTH'(tdf_pkg::MIN_VALUE);
          pend_valid_d = 1'b1;
        end
      end
      tdf_pkg::ST_CHECK: begin
        if (bound_hit) begin
          // What remains above one is itself prime.
          if (n_q > WIDTH'(1)) begin
            valid_d      = pend_valid_q;
            factor_d     = pend_q;
            pend_d       = n_q;
            pend_valid_d = 1'b1;
          end
        end else begin
          div_start = 1'b1;
        end
      end
      tdf_pkg::ST_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            n_d          = div_quot;
            valid_d      = pend_valid_q;
            factor_d     = pend_q;
            pend_d       = d_q;
            pend_valid_d = 1'b1;
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            d_d  = d_q + WIDTH'(2);
            sq_d = sq_q + {d_q, 2'b00} + SqW'(4);
          end
        end
      end
      tdf_pkg::ST_FLUSH: begin
        valid_d      = 1'b1;
        factor_d     = pend_q;
        last_d       = 1'b1;
        pend_valid_d = 1'b0;
      end
      default: begin
        pend_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tdf_pkg::ST_IDLE;
      pend_valid_q <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    d_q      <= d_d;
    sq_q     <= sq_d;
    pend_q   <= pend_d;
    factor_q <= factor_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  assign busy     = (state_q != tdf_pkg::ST_IDLE);
  assign valid_o  = valid_q;
  assign factor_o = factor_q;
  assign last_o   = last_q;
  assign status_o = status_q;

  // An error word is always the only and final word of its number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == tdf_pkg::STATUS_BELOW_TWO) |-> last_o && (factor_o == '0))
    else $error("error word without last flag or with nonzero factor");

  // A valid factor is never below two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == tdf_pkg::STATUS_OK) |-> factor_o >= WIDTH'(tdf_pkg::MIN_VALUE))
    else $error("factor word below two");

  // The divider only reports back while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == tdf_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  // Every number of two or more has a held factor to flush as its last word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tdf_pkg::ST_FLUSH |-> pend_valid_q)
    else $error("flush without a held factor");

endmodule

/* hw/rtl/tdf_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; the operands must stay stable while the division runs.
module tdf_div #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic            run_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quot_q, quot_d;
  logic [WIDTH:0]   r_shift;
  logic [WIDTH:0]   diff;

  always_comb begin
    r_shift = {rem_q, quot_q[WIDTH-1]};
    diff    = r_shift - {1'b0, divisor_i};
    // The top bit of the difference is the borrow: the divisor did not fit.
    if (diff[WIDTH]) begin
      rem_d  = r_shift[WIDTH-1:0];
      quot_d = {quot_q[WIDTH-2:0], 1'b0};
    end else begin
      rem_d  = diff[WIDTH-1:0];
      quot_d = {quot_q[WIDTH-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(WIDTH - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
    end else if (run_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for trial_division_factorizer.
// Depends on tdf_pkg for the status codes and the trial-division constants.
// A scoreboard class predicts each number's prime factors and checks the words as they come out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned MAX_WORDS = WIDTH - 1;
  localparam int unsigned STALL_LIMIT = 100000;
  localparam longint unsigned VALUE_MAX = (64'd1 << WIDTH) - 1;

  typedef struct packed {
    logic [WIDTH-1:0] factor;
    logic             last;
    logic             status;
  } factor_word_t;

  class factor_scoreboard;
    factor_word_t expected_words[$];
    int unsigned  mismatches = 0;
    int unsigned  numbers_seen = 0;
    int unsigned  words_checked = 0;
    int unsigned  below_two_seen = 0;
    int unsigned  longest_run = 0;

    // Work out every factor word for one accepted number.
    function void note_number(logic [WIDTH-1:0] value);
      longint unsigned rem;
      longint unsigned divisor;
      factor_word_t    run[$];
      factor_word_t    w;
      numbers_seen++;
      rem = 64'(value);
      if (rem < 64'(tdf_pkg::MIN_VALUE)) begin
        w.factor = '0;
        w.last = 1'b1;
        w.status = tdf_pkg::STATUS_BELOW_TWO;
        expected_words.push_back(w);
        below_two_seen++;
        return;
      end
      w.last = 1'b0;
      w.status = tdf_pkg::STATUS_OK;
      while (rem[0] == 1'b0 && run.size() < MAX_WORDS) begin
        w.factor = WIDTH'(2);
        run.push_back(w);
        rem = rem >> 1;
      end
      divisor = 64'(tdf_pkg::FIRST_ODD);
      while (divisor <= rem / divisor && run.size() < MAX_WORDS) begin
        if (rem % divisor == 0) begin
          w.factor = divisor[WIDTH-1:0];
          run.push_back(w);
          rem = rem / divisor;
        end else begin
          divisor += 2;
        end
      end
      // Whatever is left past the square-root bound is prime.
      if (rem > 1 && run.size() < MAX_WORDS) begin
        w.factor = rem[WIDTH-1:0];
        run.push_back(w);
      end
      run[run.size()-1].last = 1'b1;
      if (run.size() > longest_run) longest_run = run.size();
      foreach (run[i]) expected_words.push_back(run[i]);
    endfunction

    function void check_word(logic [WIDTH-1:0] factor, logic last, logic status);
      factor_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: factor word with none expected: factor %0d last %0b status %0b",
                 $time, factor, last, status);
        mismatches++;
        return;
      end
      exp_w = expected_words.pop_front();
      words_checked++;
      if (factor !== exp_w.factor) begin
        $display("%0t: factor mismatch: expected %0d actual %0d", $time, exp_w.factor, factor);
        mismatches++;
      end
      if (last !== exp_w.last) begin
        $display("%0t: last mismatch: expected %0b actual %0b", $time, exp_w.last, last);
        mismatches++;
      end
      if (status !== exp_w.status) begin
        $display("%0t: status mismatch: expected %0b actual %0b", $time, exp_w.status, status);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [WIDTH-1:0] number_i = '0;
  logic             valid_o;
  logic [WIDTH-1:0] factor_o;
  logic             last_o;
  logic             status_o;

  factor_scoreboard sb = new();
  int unsigned      stall_cycles = 0;

  int unsigned small_primes[24] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                                    53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

  always #5 clk_i = ~clk_i;

  trial_division_factorizer #(.WIDTH(WIDTH)) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .number_i (number_i),
    .valid_o  (valid_o),
    .factor_o (factor_o),
    .last_o   (last_o),
    .status_o (status_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_number(number_i);
      if (valid_o) sb.check_word(factor_o, last_o, status_o);
      if ((start && !busy) || valid_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the number is taken.
  task automatic send_number(input logic [WIDTH-1:0] value, input bit allow_idle);
    if (allow_idle) begin
      while ($urandom_range(99) < 22) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start <= 1'b1;
    number_i <= value;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Product of small odd primes times a few twos: deep factor lists at low cost.
  function automatic logic [WIDTH-1:0] smooth_number();
    longint unsigned acc;
    longint unsigned p;
    int unsigned     picks;
    int unsigned     twos;
    acc = 1;
    picks = $urandom_range(1, 12);
    twos = $urandom_range(0, 8);
    for (int i = 0; i < picks; i++) begin
      p = 64'(small_primes[$urandom_range(0, 23)]);
      if (acc * p <= VALUE_MAX) acc = acc * p;
    end
    while (twos > 0 && acc * 2 <= VALUE_MAX) begin
      acc = acc * 2;
      twos--;
    end
    return acc[WIDTH-1:0];
  endfunction

  initial begin
    logic [WIDTH-1:0] directed[$];
    int unsigned      kind;
    logic [WIDTH-1:0] value;

    // Below two, the smallest primes, all ones and all zeros, the longest run of twos,
    // a long run of threes, perfect squares, and primes left over after the bound.
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd15, 32'd25, 32'd49,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'd3486784401, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd3221225472, 32'd4294836225, 32'd65537,
                 32'd1000003, 32'd131074, 32'd97};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_number(directed[i], 1'b1);

    for (int i = 0; i < 80; i++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        value = $urandom_range(16383, 0);
      end else if (kind < 90) begin
        value = smooth_number();
      end else begin
        // A random value in a wider range; a large prime cofactor, where one occurs, makes the divider run long.
        value = $urandom_range(32'h0010_0000, 32'h0004_0000);
      end
      send_number(value, !(i >= 30 && i < 60));
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Factored %0d numbers (%0d below two) and checked %0d factor words.",
             sb.numbers_seen, sb.below_two_seen, sb.words_checked);
    $display("Longest factor list was %0d words; %0d mismatches found.",
             sb.longest_run, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* trial_division_factorizer.f */
hw/rtl/tdf_pkg.sv
hw/rtl/tdf_div.sv
hw/rtl/trial_division_factorizer.sv
test/tb_top.sv
